// ===== sv/lob_pkg.sv =====
// Shared types, sizes and codes for the limit order book engine.
`default_nettype none
package lob_pkg;

  // Table sizes
  localparam int ORDER_SLOTS  = 4096;
  localparam int PRICE_LEVELS = 256;
  localparam int OAW          = $clog2(ORDER_SLOTS);
  localparam int LAW          = $clog2(PRICE_LEVELS);
  localparam int NCW          = $clog2(ORDER_SLOTS + 1);
  localparam int TOTAL_W      = 48;
  localparam int MAXN         = (ORDER_SLOTS > PRICE_LEVELS) ? ORDER_SLOTS : PRICE_LEVELS;
  localparam int CW           = $clog2(MAXN);
  localparam int SW           = CW + 1;

  // Message kinds
  localparam logic [2:0] MODE_ADD = 3'd0;
  localparam logic [2:0] MODE_DEL = 3'd1;
  localparam logic [2:0] MODE_CAN = 3'd2;
  localparam logic [2:0] MODE_EXE = 3'd3;
  localparam logic [2:0] MODE_REP = 3'd4;

  // Result status
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_UNKNOWN  = 3'd1;
  localparam logic [2:0] ST_MISMATCH = 3'd2;
  localparam logic [2:0] ST_OVER     = 3'd3;
  localparam logic [2:0] ST_ORD_FULL = 3'd4;
  localparam logic [2:0] ST_LVL_FULL = 3'd5;
  localparam logic [2:0] ST_IGNORED  = 3'd6;

  // Side code of a bid ('B')
  localparam logic SIDE_BUY = 1'b1;

  typedef struct packed {
    logic [2:0]  mode;
    logic [63:0] order_ref;
    logic [63:0] replacement_id;
    logic        side;
    logic [31:0] limit_price;
    logic [31:0] share_count;
    logic [63:0] stock_code;
    logic        has_limit;
  } in_word_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] best_bid_price;
    logic [31:0] best_ask_price;
    logic [31:0] remaining_shares;
    logic        order_removed;
  } out_word_t;

  typedef struct packed {
    logic        live;
    logic [63:0] key;
    logic        is_buy;
    logic [31:0] price;
    logic [31:0] shares;
  } order_ent_t;

  typedef struct packed {
    logic [31:0]        price;
    logic [TOTAL_W-1:0] total;
    logic [NCW-1:0]     orders;
  } level_ent_t;

endpackage
`default_nettype wire

// ===== sv/lob_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module lob_ram #(
  parameter int W     = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [W-1:0]             wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [W-1:0]             rdata
);

  logic [W-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port, registered read data
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== sv/lob_core.sv =====
// Book sequencer: clearing pass, order-table scan, level scan, update and best-price rescan.
`default_nettype none
module lob_core (
  input  logic               clk,
  input  logic               rst,
  input  logic [63:0]        book_symbol,
  input  logic               in_valid,
  output logic               in_ready,
  input  lob_pkg::in_word_t  in_word,
  output logic               out_valid,
  input  logic               out_ready,
  output lob_pkg::out_word_t out_word
);
  import lob_pkg::*;

  localparam logic [3:0] S_CLR    = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_OSCAN  = 4'd2;
  localparam logic [3:0] S_DECIDE = 4'd3;
  localparam logic [3:0] S_LSCAN  = 4'd4;
  localparam logic [3:0] S_APPLY  = 4'd5;
  localparam logic [3:0] S_WRB    = 4'd6;
  localparam logic [3:0] S_BSCAN  = 4'd7;
  localparam logic [3:0] S_FIN    = 4'd8;

  localparam logic [SW-1:0] SC_ON    = SW'(ORDER_SLOTS);
  localparam logic [SW-1:0] SC_LN    = SW'(PRICE_LEVELS);
  localparam logic [SW-1:0] SC_OLAST = SW'(ORDER_SLOTS - 1);
  localparam logic [SW-1:0] SC_LLAST = SW'(PRICE_LEVELS - 1);
  localparam logic [CW-1:0] CLR_LAST = CW'(MAXN - 1);

  function automatic logic [TOTAL_W-1:0] sat_sub(input logic [TOTAL_W-1:0] t,
                                                 input logic [31:0] s);
    logic [TOTAL_W-1:0] se;
    se = TOTAL_W'(s);
    sat_sub = (t >= se) ? t - se : '0;
  endfunction

  logic [3:0]      state;
  logic [CW-1:0]   clr_cnt;
  in_word_t        msg;
  logic [SW-1:0]   sc;
  logic            rd_v;
  logic [SW-1:0]   rd_idx;
  logic            scan_go;

  // Order scan captures
  logic            hit_id;
  logic [OAW-1:0]  s_id;
  order_ent_t      ent;
  logic            hit_nid;
  logic            free_hit;
  logic [OAW-1:0]  free_slot;

  // Level scan captures
  logic            side;
  logic            old_chk;
  logic            lo_hit;
  logic [LAW-1:0]  lo_idx;
  level_ent_t      lo_ent;
  logic            ln_hit;
  logic [LAW-1:0]  ln_idx;
  level_ent_t      ln_ent;
  logic            lf_hit;
  logic [LAW-1:0]  lf_idx;

  // Second level write
  logic            b_we;
  logic [LAW-1:0]  b_idx;
  level_ent_t      b_ent;

  // Result and best prices
  logic [2:0]      res_status;
  logic [31:0]     res_remain;
  logic            res_removed;
  logic [31:0]     best_bid;
  logic [31:0]     best_ask;
  logic            ask_seen;

  // Memory ports
  logic            ord_we;
  logic [OAW-1:0]  ord_waddr;
  order_ent_t      ord_wdata;
  order_ent_t      ord_rdata;
  logic            bid_we;
  logic            ask_we;
  logic [LAW-1:0]  lv_waddr;
  level_ent_t      lv_wdata;
  level_ent_t      bid_rdata;
  level_ent_t      ask_rdata;
  level_ent_t      lv_rd;

  // Update computed from the captures
  logic [2:0]      ap_status;
  logic [31:0]     ap_remain;
  logic            ap_removed;
  logic            ap_ord_we;
  logic [OAW-1:0]  ap_ord_addr;
  order_ent_t      ap_ord_data;
  logic            ap_a_we;
  logic [LAW-1:0]  ap_a_idx;
  level_ent_t      ap_a_ent;
  logic            ap_b_we;
  logic [LAW-1:0]  ap_b_idx;
  level_ent_t      ap_b_ent;
  level_ent_t      unl_ent;
  level_ent_t      lnk_ent;
  level_ent_t      new_ent;

  lob_ram #(.W($bits(order_ent_t)), .DEPTH(ORDER_SLOTS)) u_ord (
    .clk(clk), .we(ord_we), .waddr(ord_waddr), .wdata(ord_wdata),
    .raddr(sc[OAW-1:0]), .rdata(ord_rdata)
  );

  lob_ram #(.W($bits(level_ent_t)), .DEPTH(PRICE_LEVELS)) u_bid (
    .clk(clk), .we(bid_we), .waddr(lv_waddr), .wdata(lv_wdata),
    .raddr(sc[LAW-1:0]), .rdata(bid_rdata)
  );

  lob_ram #(.W($bits(level_ent_t)), .DEPTH(PRICE_LEVELS)) u_ask (
    .clk(clk), .we(ask_we), .waddr(lv_waddr), .wdata(lv_wdata),
    .raddr(sc[LAW-1:0]), .rdata(ask_rdata)
  );

  assign in_ready = (state == S_IDLE);
  assign lv_rd    = side ? bid_rdata : ask_rdata;

  // Read issue for the three scans
  always_comb begin
    case (state)
      S_OSCAN: scan_go = (sc < SC_ON);
      S_LSCAN: scan_go = (sc < SC_LN);
      S_BSCAN: scan_go = (sc < SC_LN);
      default: scan_go = 1'b0;
    endcase
  end

  // Level entries used by the update
  always_comb begin
    unl_ent        = lo_ent;
    unl_ent.total  = sat_sub(lo_ent.total, ent.shares);
    unl_ent.orders = lo_ent.orders - NCW'(1);
    lnk_ent        = ln_ent;
    lnk_ent.total  = ln_ent.total + TOTAL_W'(msg.share_count);
    lnk_ent.orders = ln_ent.orders + NCW'(1);
    new_ent.price  = msg.limit_price;
    new_ent.total  = TOTAL_W'(msg.share_count);
    new_ent.orders = NCW'(1);
  end

  // Update for the current message
  always_comb begin
    ap_status   = ST_OK;
    ap_remain   = '0;
    ap_removed  = 1'b0;
    ap_ord_we   = 1'b0;
    ap_ord_addr = s_id;
    ap_ord_data = ent;
    ap_a_we     = 1'b0;
    ap_a_idx    = lo_idx;
    ap_a_ent    = unl_ent;
    ap_b_we     = 1'b0;
    ap_b_idx    = ln_idx;
    ap_b_ent    = lnk_ent;
    case (msg.mode)
      MODE_ADD: begin
        if (!ln_hit && !lf_hit) begin
          ap_status = ST_LVL_FULL;
        end else begin
          ap_ord_we   = 1'b1;
          ap_ord_addr = free_slot;
          ap_ord_data = '{live: 1'b1, key: msg.order_ref, is_buy: msg.side,
                          price: msg.limit_price, shares: msg.share_count};
          ap_a_we     = 1'b1;
          ap_a_idx    = ln_hit ? ln_idx : lf_idx;
          ap_a_ent    = ln_hit ? lnk_ent : new_ent;
          ap_remain   = msg.share_count;
        end
      end
      MODE_DEL: begin
        ap_ord_we        = 1'b1;
        ap_ord_data.live = 1'b0;
        ap_a_we          = lo_hit;
        ap_removed       = 1'b1;
      end
      MODE_CAN, MODE_EXE: begin
        ap_ord_we = 1'b1;
        ap_a_we   = lo_hit;
        if (msg.share_count >= ent.shares) begin
          ap_status        = (msg.share_count > ent.shares) ? ST_OVER : ST_OK;
          ap_ord_data.live = 1'b0;
          ap_removed       = 1'b1;
        end else begin
          ap_ord_data.shares = ent.shares - msg.share_count;
          ap_a_ent.total     = sat_sub(lo_ent.total, msg.share_count);
          ap_a_ent.orders    = lo_ent.orders;
          ap_remain          = ent.shares - msg.share_count;
        end
      end
      MODE_REP: begin
        if (!ln_hit && !lf_hit && !(lo_hit && lo_ent.orders == NCW'(1))) begin
          ap_status = ST_LVL_FULL;
        end else begin
          ap_ord_we   = 1'b1;
          ap_ord_data = '{live: 1'b1, key: msg.replacement_id, is_buy: ent.is_buy,
                          price: msg.limit_price, shares: msg.share_count};
          ap_remain   = msg.share_count;
          ap_a_we     = 1'b1;
          if (lo_hit) begin
            if (lo_ent.orders == NCW'(1)) begin
              // old level empties: move into an existing level or reuse it
              if (ln_hit && ln_idx != lo_idx) begin
                ap_b_we = 1'b1;
              end else begin
                ap_a_ent = new_ent;
              end
            end else if (ln_hit && ln_idx == lo_idx) begin
              ap_a_ent.total  = unl_ent.total + TOTAL_W'(msg.share_count);
              ap_a_ent.orders = lo_ent.orders;
            end else if (ln_hit) begin
              ap_b_we = 1'b1;
            end else begin
              ap_b_we  = 1'b1;
              ap_b_idx = lf_idx;
              ap_b_ent = new_ent;
            end
          end else begin
            ap_a_idx = ln_hit ? ln_idx : lf_idx;
            ap_a_ent = ln_hit ? lnk_ent : new_ent;
          end
        end
      end
      default: ap_status = ST_IGNORED;
    endcase
  end

  // Memory write selection
  always_comb begin
    ord_we    = 1'b0;
    ord_waddr = ap_ord_addr;
    ord_wdata = ap_ord_data;
    bid_we    = 1'b0;
    ask_we    = 1'b0;
    lv_waddr  = ap_a_idx;
    lv_wdata  = ap_a_ent;
    case (state)
      S_CLR: begin
        ord_we    = (clr_cnt < ORDER_SLOTS);
        ord_waddr = clr_cnt[OAW-1:0];
        ord_wdata = '0;
        bid_we    = (clr_cnt < PRICE_LEVELS);
        ask_we    = (clr_cnt < PRICE_LEVELS);
        lv_waddr  = clr_cnt[LAW-1:0];
        lv_wdata  = '0;
      end
      S_APPLY: begin
        ord_we = ap_ord_we;
        bid_we = ap_a_we && side;
        ask_we = ap_a_we && !side;
      end
      S_WRB: begin
        lv_waddr = b_idx;
        lv_wdata = b_ent;
        bid_we   = b_we && side;
        ask_we   = b_we && !side;
      end
      default: ;
    endcase
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLR;
      clr_cnt   <= '0;
      sc        <= '0;
      rd_v      <= 1'b0;
      out_valid <= 1'b0;
      best_bid  <= '0;
      best_ask  <= '0;
    end else begin
      rd_v   <= scan_go;
      rd_idx <= sc;
      if (scan_go) begin
        sc <= sc + SW'(1);
      end
      if (out_ready && state != S_FIN) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_CLR: begin
          clr_cnt <= clr_cnt + CW'(1);
          if (clr_cnt == CLR_LAST) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            msg      <= in_word;
            hit_id   <= 1'b0;
            hit_nid  <= 1'b0;
            free_hit <= 1'b0;
            sc       <= '0;
            state    <= S_OSCAN;
          end
        end
        S_OSCAN: begin
          if (rd_v) begin
            if (ord_rdata.live && ord_rdata.key == msg.order_ref && !hit_id) begin
              hit_id <= 1'b1;
              s_id   <= rd_idx[OAW-1:0];
              ent    <= ord_rdata;
            end
            if (ord_rdata.live && ord_rdata.key == msg.replacement_id) begin
              hit_nid <= 1'b1;
            end
            if (!ord_rdata.live && !free_hit) begin
              free_hit  <= 1'b1;
              free_slot <= rd_idx[OAW-1:0];
            end
            if (rd_idx == SC_OLAST) begin
              state <= S_DECIDE;
            end
          end
        end
        S_DECIDE: begin
          res_remain  <= '0;
          res_removed <= 1'b0;
          lo_hit      <= 1'b0;
          ln_hit      <= 1'b0;
          lf_hit      <= 1'b0;
          sc          <= '0;
          state       <= S_FIN;
          case (msg.mode)
            MODE_ADD: begin
              if (msg.stock_code != book_symbol) begin
                res_status <= ST_MISMATCH;
              end else if (!msg.has_limit || hit_id) begin
                res_status <= ST_IGNORED;
              end else if (!free_hit) begin
                res_status <= ST_ORD_FULL;
              end else begin
                side    <= msg.side;
                old_chk <= 1'b0;
                state   <= S_LSCAN;
              end
            end
            MODE_DEL, MODE_CAN, MODE_EXE, MODE_REP: begin
              if (!hit_id) begin
                res_status <= ST_UNKNOWN;
              end else if (msg.mode == MODE_REP && hit_nid &&
                           msg.replacement_id != msg.order_ref) begin
                res_status <= ST_IGNORED;
              end else begin
                side    <= ent.is_buy;
                old_chk <= 1'b1;
                state   <= S_LSCAN;
              end
            end
            default: res_status <= ST_IGNORED;
          endcase
        end
        S_LSCAN: begin
          if (rd_v) begin
            if (lv_rd.orders != '0 && old_chk && lv_rd.price == ent.price) begin
              lo_hit <= 1'b1;
              lo_idx <= rd_idx[LAW-1:0];
              lo_ent <= lv_rd;
            end
            if (lv_rd.orders != '0 && lv_rd.price == msg.limit_price) begin
              ln_hit <= 1'b1;
              ln_idx <= rd_idx[LAW-1:0];
              ln_ent <= lv_rd;
            end
            if (lv_rd.orders == '0 && !lf_hit) begin
              lf_hit <= 1'b1;
              lf_idx <= rd_idx[LAW-1:0];
            end
            if (rd_idx == SC_LLAST) begin
              state <= S_APPLY;
            end
          end
        end
        S_APPLY: begin
          res_status  <= ap_status;
          res_remain  <= ap_remain;
          res_removed <= ap_removed;
          b_we        <= ap_b_we;
          b_idx       <= ap_b_idx;
          b_ent       <= ap_b_ent;
          sc          <= '0;
          // book unchanged on a full level table: keep the best prices
          if (ap_status == ST_LVL_FULL) begin
            state <= S_FIN;
          end else begin
            best_bid <= '0;
            best_ask <= '0;
            ask_seen <= 1'b0;
            if (ap_b_we) begin
              state <= S_WRB;
            end else begin
              state <= S_BSCAN;
            end
          end
        end
        S_WRB: state <= S_BSCAN;
        S_BSCAN: begin
          if (rd_v) begin
            if (bid_rdata.orders != '0 && bid_rdata.price >= best_bid) begin
              best_bid <= bid_rdata.price;
            end
            if (ask_rdata.orders != '0 && (!ask_seen || ask_rdata.price < best_ask)) begin
              best_ask <= ask_rdata.price;
              ask_seen <= 1'b1;
            end
            if (rd_idx == SC_LLAST) begin
              state <= S_FIN;
            end
          end
        end
        S_FIN: begin
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            out_word  <= '{status: res_status, best_bid_price: best_bid,
                           best_ask_price: best_ask, remaining_shares: res_remain,
                           order_removed: res_removed};
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // No table write while waiting for a message
  a_idle_quiet: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> (!ord_we && !bid_we && !ask_we))
    else $error("table write while idle");

  // Only one side's level table is updated by a message
  a_one_side: assert property (@(posedge clk) disable iff (rst)
    (state != S_CLR && bid_we) |-> !ask_we)
    else $error("both level tables written by one message");

  // A finished message always lands in the output register
  a_fin_load: assert property (@(posedge clk) disable iff (rst)
    (state == S_FIN && (!out_valid || out_ready)) |=> (out_valid && in_ready))
    else $error("result not delivered to output register");

  // No message taken during the clearing pass
  a_clr_block: assert property (@(posedge clk)
    (state == S_CLR) |-> !in_ready)
    else $error("input ready during clearing pass");

endmodule
`default_nettype wire

// ===== sv/limit_order_book_engine.sv =====
// Top level of the limit order book engine: symbol register and book sequencer.
//
//  channel  direction  word                  accepted when
//  cfg      in         64-bit book symbol    cfg_valid & cfg_ready
//  in       in         lob_pkg::in_word_t    in_valid & in_ready
//  out      out        lob_pkg::out_word_t   out_valid & out_ready
//
// A message scans the order table, then the level table of its side and then both level
// tables for the best prices; the one-entry-per-cycle scan of the order table dominates.
// Messages that fail before touching the levels finish after the order scan.
// After reset a clearing pass over max(ORDER_SLOTS, PRICE_LEVELS) entries (4096)
// runs with in_ready low; cfg writes are taken at all times.
// The result sits in an output register, so a stalled out channel does not
// block the next message until its result is ready.
`default_nettype none
module limit_order_book_engine (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [63:0]        cfg_word,
  input  logic               in_valid,
  output logic               in_ready,
  input  lob_pkg::in_word_t  in_word,
  output logic               out_valid,
  input  logic               out_ready,
  output lob_pkg::out_word_t out_word
);
  import lob_pkg::*;

  logic [63:0] book_symbol;

  assign cfg_ready = 1'b1;

  // Symbol register
  always_ff @(posedge clk) begin
    if (rst) begin
      book_symbol <= '0;
    end else if (cfg_valid) begin
      book_symbol <= cfg_word;
    end
  end

  lob_core u_core (
    .clk(clk), .rst(rst), .book_symbol(book_symbol),
    .in_valid(in_valid), .in_ready(in_ready), .in_word(in_word),
    .out_valid(out_valid), .out_ready(out_ready), .out_word(out_word)
  );

endmodule
`default_nettype wire
